// ----- sv/rcfd_pkg.sv -----
package rcfd_pkg;

   localparam int CH_W        = 11;
   localparam int NUM_STICKS  = 4;
   localparam int SW_W        = 2;
   localparam int STORE_BYTES = 6;
   localparam int STORE_IDX_W = 3;
   localparam int GAP_W       = 16;
   localparam int LINK_CFG_W  = 20;
   localparam int LINK_W      = 21;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 20;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_TIMEOUT  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_MIN   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_MAX   = 4'd3;

   // Request kinds.
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [GAP_W-1:0]      GAP_THRESHOLD_RST = 16'd3000;
   localparam logic [LINK_CFG_W-1:0] LINK_TIMEOUT_RST  = 20'd100000;
   localparam logic [CH_W-1:0]       CHANNEL_MIN_RST   = 11'd200;
   localparam logic [CH_W-1:0]       CHANNEL_MAX_RST   = 11'd1800;
   localparam logic [CH_W-1:0]       STICK_RST         = 11'd1024;
   localparam logic [SW_W-1:0]       SWITCH_RST        = 2'd0;
   localparam logic [GAP_W-1:0]      GAP_SAT           = '1;
   localparam logic [LINK_W-1:0]     LINK_SAT          = '1;

   typedef logic [STORE_BYTES-1:0][7:0]     byte_array_type;
   typedef logic [NUM_STICKS-1:0][CH_W-1:0] stick_array_type;

   typedef struct packed {
      logic [GAP_W-1:0]      gap_threshold;
      logic [LINK_CFG_W-1:0] link_timeout;
      logic [CH_W-1:0]       channel_min;
      logic [CH_W-1:0]       channel_max;
   } cfg_type;

   typedef struct packed {
      stick_array_type sticks;
      logic [SW_W-1:0] switch_1;
      logic [SW_W-1:0] switch_2;
      logic            in_range;
   } decode_type;

endpackage

// ----- sv/rcfd_csr.sv -----
module rcfd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rcfd_pkg::cfg_type                  cfg
);
   import rcfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAP_THRESHOLD: cfg_in.gap_threshold = csr_wdata[GAP_W-1:0];
            CSR_LINK_TIMEOUT:  cfg_in.link_timeout  = csr_wdata[LINK_CFG_W-1:0];
            CSR_CHANNEL_MIN:   cfg_in.channel_min   = csr_wdata[CH_W-1:0];
            CSR_CHANNEL_MAX:   cfg_in.channel_max   = csr_wdata[CH_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_threshold <= GAP_THRESHOLD_RST;
         cfg_ff.link_timeout  <= LINK_TIMEOUT_RST;
         cfg_ff.channel_min   <= CHANNEL_MIN_RST;
         cfg_ff.channel_max   <= CHANNEL_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/rcfd_decode.sv -----
module rcfd_decode (
   input  rcfd_pkg::byte_array_type frame_bytes,
   input  rcfd_pkg::cfg_type        cfg,
   output rcfd_pkg::decode_type     dec
);
   import rcfd_pkg::*;

   stick_array_type ch;
   logic [NUM_STICKS-1:0] ok;

   // Sticks are packed LSB first, 11 bits each, across the first bytes.
   assign ch[0] = {frame_bytes[1][2:0], frame_bytes[0]};
   assign ch[1] = {frame_bytes[2][5:0], frame_bytes[1][7:3]};
   assign ch[2] = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
   assign ch[3] = {frame_bytes[5][3:0], frame_bytes[4][7:1]};

   always_comb begin
      for (int i = 0; i < NUM_STICKS; i++) begin
         ok[i] = (ch[i] >= cfg.channel_min) && (ch[i] <= cfg.channel_max);
      end
   end

   assign dec.sticks   = ch;
   assign dec.switch_1 = frame_bytes[5][7:6];
   assign dec.switch_2 = frame_bytes[5][5:4];
   assign dec.in_range = &ok;

endmodule

// ----- sv/rc_receiver_frame_decoder_core.sv -----
// Channel   Direction  Handshake              Contents
// req_      in         req_valid / req_stall  mode, received byte
// rsp_      out        rsp_valid / rsp_stall  held sticks, switches, link, frame pulses
// csr_      in         csr_valid / csr_ready  register index, write data
//
// One request is taken every cycle unless a stalled response holds the request register.
// The request register feeds one pass of decode and timer logic into the response register.
// Reset (synchronous) restores the register defaults, saturates both timers (link offline)
// and sets the sticks to mid scale. No clearing pass follows reset.
// A stalled response holds the request register, which then stalls requests.
module rc_receiver_frame_decoder_core #(
   parameter int FRAME_BYTES = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rcfd_pkg::CH_W-1:0]         rsp_stick_0,
   output logic [rcfd_pkg::CH_W-1:0]         rsp_stick_1,
   output logic [rcfd_pkg::CH_W-1:0]         rsp_stick_2,
   output logic [rcfd_pkg::CH_W-1:0]         rsp_stick_3,
   output logic [rcfd_pkg::SW_W-1:0]         rsp_switch_1,
   output logic [rcfd_pkg::SW_W-1:0]         rsp_switch_2,
   output logic                              rsp_link_online,
   output logic                              rsp_frame_accepted,
   output logic                              rsp_frame_rejected,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rcfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rcfd_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] STORE_LIMIT = POS_W'(STORE_BYTES);

   cfg_type    cfg;
   decode_type dec;

   // Request register.
   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;

   // Decoder state.
   byte_array_type  store_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   logic [LINK_W-1:0] link_ff, link_in;
   stick_array_type sticks_ff, sticks_in;
   logic [SW_W-1:0] sw1_ff, sw1_in, sw2_ff, sw2_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic online_ff, accepted_ff, rejected_ff;
   logic accepted_in, rejected_in;

   logic req_take, advance, is_byte, store_we, frame_done;
   logic [POS_W-1:0] pos_start, pos_next;
   byte_array_type view;

   rcfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcfd_decode u_decode (
      .frame_bytes (view),
      .cfg         (cfg),
      .dec         (dec)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_stall) ? 1'b1 : 1'b0);

   assign is_byte   = (in_mode_ff == MODE_BYTE);
   // A long enough idle gap restarts the frame at this byte.
   assign pos_start = (gap_ff > cfg.gap_threshold) ? '0 : pos_ff;
   assign pos_next  = pos_start + 1'b1;
   assign store_we  = advance && is_byte && (pos_start < STORE_LIMIT);
   assign frame_done = is_byte && (pos_next == LAST_POS);

   // The decoder sees the store with the current byte already in place.
   always_comb begin
      view = store_ff;
      if (is_byte && (pos_start < STORE_LIMIT)) begin
         view[pos_start[STORE_IDX_W-1:0]] = in_byte_ff;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      gap_in      = gap_ff;
      link_in     = link_ff;
      sticks_in   = sticks_ff;
      sw1_in      = sw1_ff;
      sw2_in      = sw2_ff;
      accepted_in = 1'b0;
      rejected_in = 1'b0;
      if (advance) begin
         if (!is_byte) begin
            if (gap_ff != GAP_SAT) begin
               gap_in = gap_ff + 1'b1;
            end
            if (link_ff != LINK_SAT) begin
               link_in = link_ff + 1'b1;
            end
         end else begin
            gap_in = '0;
            pos_in = pos_next;
            if (frame_done) begin
               pos_in = '0;
               if (dec.in_range) begin
                  sticks_in   = dec.sticks;
                  sw1_in      = dec.switch_1;
                  sw2_in      = dec.switch_2;
                  link_in     = '0;
                  accepted_in = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         gap_ff       <= GAP_SAT;
         link_ff      <= LINK_SAT;
         for (int i = 0; i < NUM_STICKS; i++) begin
            sticks_ff[i] <= STICK_RST;
         end
         sw1_ff <= SWITCH_RST;
         sw2_ff <= SWITCH_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         gap_ff       <= gap_in;
         link_ff      <= link_in;
         sticks_ff    <= sticks_in;
         sw1_ff       <= sw1_in;
         sw2_ff       <= sw2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_rx_byte;
      end
      if (store_we) begin
         store_ff[pos_start[STORE_IDX_W-1:0]] <= in_byte_ff;
      end
      if (advance) begin
         online_ff   <= (link_in <= {1'b0, cfg.link_timeout});
         accepted_ff <= accepted_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stick_0        = sticks_ff[0];
   assign rsp_stick_1        = sticks_ff[1];
   assign rsp_stick_2        = sticks_ff[2];
   assign rsp_stick_3        = sticks_ff[3];
   assign rsp_switch_1       = sw1_ff;
   assign rsp_switch_2       = sw2_ff;
   assign rsp_link_online    = online_ff;
   assign rsp_frame_accepted = accepted_ff;
   assign rsp_frame_rejected = rejected_ff;

`ifndef ASSERT_OFF
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(accepted_ff && rejected_ff))
      else $error("accept and reject pulses set together");

   a_accept_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && accepted_ff) |-> online_ff)
      else $error("link offline right after an accepted frame");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && rejected_in) |=> ($stable(sticks_ff) && $stable(sw1_ff) && $stable(sw2_ff)))
      else $error("held values changed on a rejected frame");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < LAST_POS)
      else $error("byte position reached the frame length");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline can move");
`endif

endmodule
